// ----- hdl/qte_pkg.sv -----
// Shared constants for the quaternion to Euler angle pipeline.
package qte_pkg;

    localparam int ANGLE_W    = 34;   // Q30 radian accumulator width
    localparam int OUT_W      = 24;   // output angle width, 13 fraction bits
    localparam int NORM_EXP   = 40;   // CORDIC operands are scaled to at least 2^40
    localparam int ATAN_LEN   = 24;
    localparam int QUO_BITS   = 30;   // fraction bits of the arcsine ratio
    localparam int SQRT_STEPS = 31;

    localparam logic signed [ANGLE_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic [29:0] DEG_K = 30'd961263669;
    localparam logic [OUT_W-1:0] FULL_TURN_Q13 = 24'd2949120;

    localparam logic [30:0] ATAN_Q30 [ATAN_LEN] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
        31'd262144,    31'd131072,    31'd65536,     31'd32768,
        31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128
    };

endpackage

// ----- hdl/qte_front.sv -----
// Front end: component capture, pairwise products and the atan2 / arcsine operands.
module qte_front #(
    parameter int QUAT_WIDTH = 16,
    localparam int EW   = (QUAT_WIDTH > 24) ? 24 : QUAT_WIDTH,
    localparam int DROP = QUAT_WIDTH - EW,
    localparam int PW   = 2 * EW + 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [QUAT_WIDTH-1:0] quat_real,
    input  logic signed [QUAT_WIDTH-1:0] quat_i,
    input  logic signed [QUAT_WIDTH-1:0] quat_j,
    input  logic signed [QUAT_WIDTH-1:0] quat_k,
    output logic                         out_valid,
    output logic                         zero,
    output logic signed [PW-1:0]         yaw_y,
    output logic signed [PW-1:0]         yaw_x,
    output logic signed [PW-1:0]         roll_y,
    output logic signed [PW-1:0]         roll_x,
    output logic signed [PW-1:0]         p,
    output logic [PW-1:0]                norm
);

    logic signed [QUAT_WIDTH-1:0] sh_r, sh_i, sh_j, sh_k;
    logic signed [EW-1:0] qr_reg, qi_reg, qj_reg, qk_reg;
    logic signed [2*EW-1:0] rr_reg, ii_reg, jj_reg, kk_reg;
    logic signed [2*EW-1:0] ij_reg, kr_reg, jk_reg, ir_reg, jr_reg, ik_reg;
    logic signed [PW-1:0] e_rr, e_ii, e_jj, e_kk, e_ij, e_kr, e_jk, e_ir, e_jr, e_ik;
    logic signed [PW-1:0] norm_next;
    logic v1_reg, v2_reg, v3_reg;
    logic zero_reg;
    logic signed [PW-1:0] yaw_y_reg, yaw_x_reg, roll_y_reg, roll_x_reg, p_reg;
    logic [PW-1:0] norm_reg;

    // drop the low bits of wide components
    assign sh_r = quat_real >>> DROP;
    assign sh_i = quat_i >>> DROP;
    assign sh_j = quat_j >>> DROP;
    assign sh_k = quat_k >>> DROP;

    assign e_rr = PW'(rr_reg);
    assign e_ii = PW'(ii_reg);
    assign e_jj = PW'(jj_reg);
    assign e_kk = PW'(kk_reg);
    assign e_ij = PW'(ij_reg);
    assign e_kr = PW'(kr_reg);
    assign e_jk = PW'(jk_reg);
    assign e_ir = PW'(ir_reg);
    assign e_jr = PW'(jr_reg);
    assign e_ik = PW'(ik_reg);
    assign norm_next = e_ii + e_jj + e_kk + e_rr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qr_reg <= sh_r[EW-1:0];
            qi_reg <= sh_i[EW-1:0];
            qj_reg <= sh_j[EW-1:0];
            qk_reg <= sh_k[EW-1:0];

            rr_reg <= qr_reg * qr_reg;
            ii_reg <= qi_reg * qi_reg;
            jj_reg <= qj_reg * qj_reg;
            kk_reg <= qk_reg * qk_reg;
            ij_reg <= qi_reg * qj_reg;
            kr_reg <= qk_reg * qr_reg;
            jk_reg <= qj_reg * qk_reg;
            ir_reg <= qi_reg * qr_reg;
            jr_reg <= qj_reg * qr_reg;
            ik_reg <= qi_reg * qk_reg;

            yaw_y_reg  <= (e_ij + e_kr) <<< 1;
            yaw_x_reg  <= e_ii - e_jj - e_kk + e_rr;
            roll_y_reg <= (e_jk + e_ir) <<< 1;
            roll_x_reg <= e_kk + e_rr - e_ii - e_jj;
            p_reg      <= (e_jr - e_ik) <<< 1;
            norm_reg   <= norm_next;
            zero_reg   <= (norm_next == '0);
        end
    end

    assign out_valid = v3_reg;
    assign zero      = zero_reg;
    assign yaw_y     = yaw_y_reg;
    assign yaw_x     = yaw_x_reg;
    assign roll_y    = roll_y_reg;
    assign roll_x    = roll_x_reg;
    assign p         = p_reg;
    assign norm      = norm_reg;

endmodule

// ----- hdl/qte_asin.sv -----
// Arcsine operand: pipelined ratio divider, squaring and pipelined integer square root.
module qte_asin #(
    parameter int PW = 34,
    parameter int SW = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [PW-1:0] p,
    input  logic [PW-1:0]        norm,
    input  logic [SW-1:0]        side_i,
    output logic                 out_valid,
    output logic signed [31:0]   t,
    output logic [30:0]          c,
    output logic [SW-1:0]        side_o
);

    localparam int DN = qte_pkg::QUO_BITS;
    localparam int SN = qte_pkg::SQRT_STEPS;

    logic          dv_reg  [DN+1];
    logic [PW-1:0] r_reg   [DN+1];
    logic [29:0]   q_reg   [DN+1];
    logic [PW-1:0] nm_reg  [DN+1];
    logic          neg_reg [DN+1];
    logic          sat_reg [DN+1];
    logic [SW-1:0] sd_reg  [DN+1];

    logic          fv_reg;
    logic [30:0]   fq_reg;
    logic [61:0]   fsq_reg;
    logic          fneg_reg;
    logic [SW-1:0] fsd_reg;

    logic          sv_reg   [SN+1];
    logic [61:0]   sn_reg   [SN+1];
    logic [61:0]   sr_reg   [SN+1];
    logic [30:0]   sq_reg   [SN+1];
    logic          sneg_reg [SN+1];
    logic [SW-1:0] ssd_reg  [SN+1];

    logic [PW-1:0] mag_p;
    logic [30:0]   q_sat;
    logic [31:0]   q_ext;

    assign mag_p = p[PW-1] ? PW'(-p) : PW'(p);
    assign q_sat = sat_reg[DN] ? 31'(1 << DN) : {1'b0, q_reg[DN]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= mag_p;
            q_reg[0]   <= '0;
            nm_reg[0]  <= norm;
            neg_reg[0] <= p[PW-1];
            sat_reg[0] <= (mag_p >= norm);
            sd_reg[0]  <= side_i;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= DN; k++) begin : g_div
        logic [PW-1:0] rs;
        logic          ge;
        assign rs = {r_reg[k-1][PW-2:0], 1'b0};
        assign ge = (rs >= nm_reg[k-1]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (en) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]   <= ge ? rs - nm_reg[k-1] : rs;
                q_reg[k]   <= {q_reg[k-1][28:0], ge};
                nm_reg[k]  <= nm_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                sd_reg[k]  <= sd_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg    <= 1'b0;
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            fv_reg    <= dv_reg[DN];
            sv_reg[0] <= fv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fq_reg      <= q_sat;
            fsq_reg     <= q_sat * q_sat;
            fneg_reg    <= neg_reg[DN];
            fsd_reg     <= sd_reg[DN];
            sn_reg[0]   <= (62'd1 << 60) - fsq_reg;
            sr_reg[0]   <= '0;
            sq_reg[0]   <= fq_reg;
            sneg_reg[0] <= fneg_reg;
            ssd_reg[0]  <= fsd_reg;
        end
    end

    // one result bit per stage, bit weight falling by four each step
    for (genvar j = 1; j <= SN; j++) begin : g_sqrt
        localparam logic [61:0] ONE = 62'd1 << (62 - 2 * j);
        logic [61:0] trial;
        logic        ge;
        assign trial = sr_reg[j-1] + ONE;
        assign ge    = (sn_reg[j-1] >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[j] <= 1'b0;
            end else if (en) begin
                sv_reg[j] <= sv_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sn_reg[j]   <= ge ? sn_reg[j-1] - trial : sn_reg[j-1];
                sr_reg[j]   <= ge ? (sr_reg[j-1] >> 1) + ONE : (sr_reg[j-1] >> 1);
                sq_reg[j]   <= sq_reg[j-1];
                sneg_reg[j] <= sneg_reg[j-1];
                ssd_reg[j]  <= ssd_reg[j-1];
            end
        end
    end

    assign q_ext     = {1'b0, sq_reg[SN]};
    assign t         = sneg_reg[SN] ? -$signed(q_ext) : $signed(q_ext);
    assign c         = sr_reg[SN][30:0];
    assign side_o    = ssd_reg[SN];
    assign out_valid = sv_reg[SN];

    // an unsaturated ratio leaves a remainder below the norm
    a_rem_below_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg[DN] && !sat_reg[DN] |-> r_reg[DN] < nm_reg[DN])
        else $error("divider remainder not below norm");

endmodule

// ----- hdl/qte_cordic.sv -----
// Vectoring CORDIC lane: quadrant fold, operand scaling and unrolled micro-rotations.
module qte_cordic #(
    parameter int CW    = 44,
    parameter int STEPS = 16,
    parameter int SW    = 1,
    localparam int ZW   = qte_pkg::ANGLE_W,
    localparam int NS   = 7 + STEPS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] x_i,
    input  logic signed [CW-1:0] y_i,
    input  logic [SW-1:0]        side_i,
    output logic                 out_valid,
    output logic signed [ZW-1:0] z_o,
    output logic [SW-1:0]        side_o
);

    logic                 va_reg  [NS];
    logic signed [CW-1:0] xa_reg  [NS];
    logic signed [CW-1:0] ya_reg  [NS];
    logic signed [ZW-1:0] za_reg  [NS];
    logic                 byp_reg [NS];
    logic [SW-1:0]        sd_reg  [NS];

    logic x_neg, both_zero;

    assign x_neg     = x_i[CW-1];
    assign both_zero = (x_i == '0) && (y_i == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg[0] <= 1'b0;
        end else if (en) begin
            va_reg[0] <= in_valid;
        end
    end

    // fold the left half plane onto the right, start the angle at +/- pi
    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg[0]  <= x_neg ? -x_i : x_i;
            ya_reg[0]  <= x_neg ? -y_i : y_i;
            if (both_zero || !x_neg) begin
                za_reg[0] <= '0;
            end else begin
                za_reg[0] <= y_i[CW-1] ? -qte_pkg::PI_Q30 : qte_pkg::PI_Q30;
            end
            byp_reg[0] <= both_zero || (y_i == '0);
            sd_reg[0]  <= side_i;
        end
    end

    for (genvar g = 1; g < NS; g++) begin : g_stage
        logic signed [CW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;

        if (g <= 6) begin : g_scale
            // binary search of the doubling count, largest shift first
            localparam int AMT = 1 << (6 - g);
            logic [CW-1:0] mx, my, mo;
            logic          fits;
            assign mx     = xa_reg[g-1];
            assign my     = ya_reg[g-1][CW-1] ? CW'(-ya_reg[g-1]) : CW'(ya_reg[g-1]);
            assign mo     = mx | my;
            assign fits   = ((mo >> (qte_pkg::NORM_EXP + 1 - AMT)) == '0);
            assign x_next = fits ? xa_reg[g-1] <<< AMT : xa_reg[g-1];
            assign y_next = fits ? ya_reg[g-1] <<< AMT : ya_reg[g-1];
            assign z_next = za_reg[g-1];
        end else begin : g_rot
            localparam int I = g - 7;
            logic signed [CW-1:0] xs, ys;
            logic signed [ZW-1:0] ang;
            assign xs  = xa_reg[g-1] >>> I;
            assign ys  = ya_reg[g-1] >>> I;
            assign ang = $signed({{(ZW-31){1'b0}}, qte_pkg::ATAN_Q30[I]});
            always_comb begin
                if (byp_reg[g-1]) begin
                    x_next = xa_reg[g-1];
                    y_next = ya_reg[g-1];
                    z_next = za_reg[g-1];
                end else if (!ya_reg[g-1][CW-1]) begin
                    x_next = xa_reg[g-1] + ys;
                    y_next = ya_reg[g-1] - xs;
                    z_next = za_reg[g-1] + ang;
                end else begin
                    x_next = xa_reg[g-1] - ys;
                    y_next = ya_reg[g-1] + xs;
                    z_next = za_reg[g-1] - ang;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg[g] <= 1'b0;
            end else if (en) begin
                va_reg[g] <= va_reg[g-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                xa_reg[g]  <= x_next;
                ya_reg[g]  <= y_next;
                za_reg[g]  <= z_next;
                byp_reg[g] <= byp_reg[g-1];
                sd_reg[g]  <= sd_reg[g-1];
            end
        end
    end

    assign out_valid = va_reg[NS-1];
    assign z_o       = za_reg[NS-1];
    assign side_o    = sd_reg[NS-1];

    // x only grows once folded into the right half plane
    a_x_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg[NS-1] |-> !xa_reg[NS-1][CW-1])
        else $error("CORDIC x went negative");

endmodule

// ----- hdl/qte_scale.sv -----
// Output scaling: Q30 radians to 13 fraction bits in radians or degrees, yaw wrap.
module qte_scale #(
    localparam int ZW = qte_pkg::ANGLE_W,
    localparam int OW = qte_pkg::OUT_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic                 deg,
    input  logic                 zero_i,
    input  logic signed [ZW-1:0] yaw_z,
    input  logic signed [ZW-1:0] pitch_z,
    input  logic signed [ZW-1:0] roll_z,
    output logic                 out_valid,
    output logic signed [OW-1:0] yaw,
    output logic signed [OW-1:0] pitch,
    output logic signed [OW-1:0] roll,
    output logic                 zero_o
);

    localparam int LB = 17;   // low part of the split degree product

    logic signed [ZW-1:0] z_in [3];
    logic signed [OW-1:0] res_reg [3];
    logic signed [OW-1:0] ang_reg [3];
    logic va_reg, vb_reg, vc_reg;
    logic za_reg, zb_reg, zc_reg;

    assign z_in[0] = yaw_z;
    assign z_in[1] = pitch_z;
    assign z_in[2] = roll_z;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic signed [ZW-LB-1:0] zh;
        logic [LB-1:0]           zl;
        logic signed [40:0]      rad_sum;
        logic signed [47:0]      hk_reg;
        logic [46:0]             lk_reg;
        logic signed [OW-1:0]    rad_reg;
        logic signed [64:0]      deg_sum;

        assign zh      = z_in[l][ZW-1:LB];
        assign zl      = z_in[l][LB-1:0];
        assign rad_sum = 41'(z_in[l]) + 41'sd65536;
        assign deg_sum = (65'(hk_reg) <<< LB) + $signed({18'd0, lk_reg})
                       + (65'sd1 <<< 40);

        always_ff @(posedge aclk) begin
            if (en) begin
                hk_reg     <= zh * $signed({1'b0, qte_pkg::DEG_K});
                lk_reg     <= zl * qte_pkg::DEG_K;
                rad_reg    <= rad_sum[40:LB];
                res_reg[l] <= deg ? deg_sum[64:41] : rad_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            za_reg <= zero_i;
            zb_reg <= za_reg;
            zc_reg <= zb_reg;
            if (zb_reg) begin
                ang_reg[0] <= '0;
                ang_reg[1] <= '0;
                ang_reg[2] <= '0;
            end else begin
                // lift a negative degree yaw into 0..360
                ang_reg[0] <= (deg && res_reg[0][OW-1]) ?
                              res_reg[0] + $signed(qte_pkg::FULL_TURN_Q13) : res_reg[0];
                ang_reg[1] <= res_reg[1];
                ang_reg[2] <= res_reg[2];
            end
        end
    end

    assign out_valid = vc_reg;
    assign yaw       = ang_reg[0];
    assign pitch     = ang_reg[1];
    assign roll      = ang_reg[2];
    assign zero_o    = zc_reg;

endmodule

// ----- hdl/quaternion_to_euler_angles_core.sv -----
// Top level: quaternion to ZYX Euler angles (yaw, pitch, roll), fully pipelined.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_quat_real, s_quat_i, s_quat_j, s_quat_k
//  m_      | out       | m_valid / m_ready  | m_yaw_angle, m_pitch_angle, m_roll_angle,
//          |           |                    | m_zero_norm
//  cfg_    | in        | cfg_we             | cfg_wdata (angle_in_degrees)
//
//  One quaternion per cycle enters while the pipeline is not stalled; the depth is set
//  by the 30-stage ratio divider, the 31-stage square root and the CORDIC rotations.
//  All stages advance together on one enable; the output register frees it when empty
//  or when m_ready takes the waiting transfer, so s_ready stays high under a taken output.
//  A stall freezes every stage in place: nothing is dropped or repeated.
//  aresetn is synchronous, active low; it clears the valid bits and selects radians.
module quaternion_to_euler_angles_core #(
    parameter int QUAT_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [QUAT_WIDTH-1:0] s_quat_real,
    input  logic signed [QUAT_WIDTH-1:0] s_quat_i,
    input  logic signed [QUAT_WIDTH-1:0] s_quat_j,
    input  logic signed [QUAT_WIDTH-1:0] s_quat_k,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [23:0]           m_yaw_angle,
    output logic signed [23:0]           m_pitch_angle,
    output logic signed [23:0]           m_roll_angle,
    output logic                         m_zero_norm,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata
);

    localparam int EW = (QUAT_WIDTH > 24) ? 24 : QUAT_WIDTH;
    localparam int PW = 2 * EW + 2;                       // product sum width
    localparam int CW = (2 * EW + 4 > 44) ? 2 * EW + 4 : 44;  // CORDIC datapath width
    localparam int SW = 4 * PW + 1;                       // operands riding with the divider
    localparam int ZW = qte_pkg::ANGLE_W;

    logic en;
    logic angle_in_degrees_reg;

    logic f_valid, f_zero;
    logic signed [PW-1:0] f_yaw_y, f_yaw_x, f_roll_y, f_roll_x, f_p;
    logic [PW-1:0] f_norm;

    logic a_valid;
    logic signed [31:0] a_t;
    logic [30:0] a_c;
    logic [SW-1:0] a_side;

    logic signed [CW-1:0] yaw_y_c, yaw_x_c, roll_y_c, roll_x_c, pitch_y_c, pitch_x_c;
    logic c_valid_yaw, c_valid_pitch, c_valid_roll;
    logic signed [ZW-1:0] z_yaw, z_pitch, z_roll;
    logic c_zero;

    // whole pipeline moves when the output register is empty or being drained
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // configuration: must be written while idle, which the block does not enforce; no handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_in_degrees_reg <= 1'b0;
        end else if (cfg_we) begin
            angle_in_degrees_reg <= cfg_wdata;
        end
    end

    qte_front #(.QUAT_WIDTH(QUAT_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .quat_real (s_quat_real),
        .quat_i    (s_quat_i),
        .quat_j    (s_quat_j),
        .quat_k    (s_quat_k),
        .out_valid (f_valid),
        .zero      (f_zero),
        .yaw_y     (f_yaw_y),
        .yaw_x     (f_yaw_x),
        .roll_y    (f_roll_y),
        .roll_x    (f_roll_x),
        .p         (f_p),
        .norm      (f_norm)
    );

    // yaw and roll operands ride alongside the arcsine divider and root
    qte_asin #(.PW(PW), .SW(SW)) u_asin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .p         (f_p),
        .norm      (f_norm),
        .side_i    ({f_zero, f_yaw_y, f_yaw_x, f_roll_y, f_roll_x}),
        .out_valid (a_valid),
        .t         (a_t),
        .c         (a_c),
        .side_o    (a_side)
    );

    assign yaw_y_c   = CW'($signed(a_side[4*PW-1:3*PW]));
    assign yaw_x_c   = CW'($signed(a_side[3*PW-1:2*PW]));
    assign roll_y_c  = CW'($signed(a_side[2*PW-1:PW]));
    assign roll_x_c  = CW'($signed(a_side[PW-1:0]));
    assign pitch_y_c = CW'(a_t);
    assign pitch_x_c = CW'($signed({1'b0, a_c}));

    qte_cordic #(.CW(CW), .STEPS(CORDIC_STEPS), .SW(1)) u_cordic_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_valid),
        .x_i       (yaw_x_c),
        .y_i       (yaw_y_c),
        .side_i    (1'b0),
        .out_valid (c_valid_yaw),
        .z_o       (z_yaw),
        .side_o    ()
    );

    // pitch lane carries the zero-norm flag
    qte_cordic #(.CW(CW), .STEPS(CORDIC_STEPS), .SW(1)) u_cordic_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_valid),
        .x_i       (pitch_x_c),
        .y_i       (pitch_y_c),
        .side_i    (a_side[SW-1]),
        .out_valid (c_valid_pitch),
        .z_o       (z_pitch),
        .side_o    (c_zero)
    );

    qte_cordic #(.CW(CW), .STEPS(CORDIC_STEPS), .SW(1)) u_cordic_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_valid),
        .x_i       (roll_x_c),
        .y_i       (roll_y_c),
        .side_i    (1'b0),
        .out_valid (c_valid_roll),
        .z_o       (z_roll),
        .side_o    ()
    );

    // last stage of the scaler is the output register
    qte_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_pitch),
        .deg       (angle_in_degrees_reg),
        .zero_i    (c_zero),
        .yaw_z     (z_yaw),
        .pitch_z   (z_pitch),
        .roll_z    (z_roll),
        .out_valid (m_valid),
        .yaw       (m_yaw_angle),
        .pitch     (m_pitch_angle),
        .roll      (m_roll_angle),
        .zero_o    (m_zero_norm)
    );

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_yaw == c_valid_pitch) && (c_valid_roll == c_valid_pitch))
        else $error("CORDIC lanes out of step");

    a_zero_norm_angles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_norm |->
            (m_yaw_angle == '0) && (m_pitch_angle == '0) && (m_roll_angle == '0))
        else $error("zero-norm result carries nonzero angles");

endmodule

// ----- verif/tb.sv -----
// Testbench for the quaternion to Euler angle core: directed table, random traffic, predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QW         = 16;
    localparam int STEPS      = 16;
    localparam int LATENCY    = 77 + STEPS;
    localparam int WATCHDOG   = 20000;
    localparam int N_RANDOM   = 1300;

    // CORDIC arctangent table in Q30 radians
    localparam longint ATAN_TAB [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };
    localparam longint PI_FIX    = 64'sd3373259426;
    localparam longint RAD2DEG_K = 64'sd961263669;
    localparam longint TURN_Q13  = 64'sd2949120;

    typedef struct packed {
        logic signed [QW-1:0] qr;
        logic signed [QW-1:0] qi;
        logic signed [QW-1:0] qj;
        logic signed [QW-1:0] qk;
    } quat_t;

    typedef struct packed {
        logic signed [23:0] yaw;
        logic signed [23:0] pitch;
        logic signed [23:0] roll;
        logic               zero;
    } euler_t;

    // One directed row: quaternion plus an optional typed-in answer
    typedef struct {
        quat_t  q;
        bit     fixed;
        euler_t ans;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [QW-1:0] s_quat_real = '0, s_quat_i = '0, s_quat_j = '0, s_quat_k = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [23:0] m_yaw_angle, m_pitch_angle, m_roll_angle;
    logic m_zero_norm;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    bit     degrees_mode;      // the predictor's copy of the unit register
    euler_t angle_queue [$];
    int     mismatches = 0;
    int     checked = 0;
    int     idle_count = 0;
    bit     rx_quiet = 1'b0;   // no receiver stalls in the tail of the run
    bit     rx_hold = 1'b0;    // long receiver hold-off to back up the pipeline
    int     n_deg = 0, n_rad = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    quaternion_to_euler_angles_core #(.QUAT_WIDTH(QW), .CORDIC_STEPS(STEPS)) u_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_quat_real, .s_quat_i, .s_quat_j, .s_quat_k,
        .m_valid, .m_ready, .m_yaw_angle, .m_pitch_angle, .m_roll_angle, .m_zero_norm,
        .cfg_we, .cfg_wdata
    );

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Vectoring CORDIC; result in Q30 radians
    function automatic longint cordic_atan2(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_FIX : -PI_FIX;
            x = -x;
            y = -y;
        end
        if (y == 0) return z;
        while (abs64(x) < (64'sd1 <<< 40) && abs64(y) < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z += ATAN_TAB[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, one;
        res = 0;
        one = 64'd1 << 62;
        while (one > n) one >>= 2;
        while (one != 0) begin
            if (n >= res + one) begin
                n -= res + one;
                res = (res >> 1) + one;
            end else begin
                res >>= 1;
            end
            one >>= 2;
        end
        return res;
    endfunction

    // Round Q30 radians down to 13 fraction bits, in the selected unit
    function automatic longint scale_angle(longint z);
        if (degrees_mode) return asr(z * RAD2DEG_K + (64'sd1 <<< 40), 41);
        return asr(z + (64'sd1 <<< 16), 17);
    endfunction

    function automatic euler_t predict_euler(quat_t q);
        euler_t e;
        longint r, i, j, k, sr, si, sj, sk, norm, p, yaw, t;
        longint unsigned a, quo, rem, c;
        r = q.qr; i = q.qi; j = q.qj; k = q.qk;
        sr = r * r; si = i * i; sj = j * j; sk = k * k;
        norm = sr + si + sj + sk;
        e = '0;
        if (norm == 0) begin
            e.zero = 1'b1;
            return e;
        end
        yaw = scale_angle(cordic_atan2(2 * (i * j + k * r), si - sj - sk + sr));
        e.roll = scale_angle(cordic_atan2(2 * (j * k + i * r), -si - sj + sk + sr));
        p = 2 * (j * r - i * k);
        a = abs64(p);
        if (a >= norm) begin
            quo = 64'd1 << 30;
        end else begin
            quo = 0;
            rem = a;
            for (int b = 0; b < 30; b++) begin
                rem <<= 1;
                quo <<= 1;
                if (rem >= norm) begin
                    rem -= norm;
                    quo |= 1;
                end
            end
        end
        c = int_sqrt((64'd1 << 60) - quo * quo);
        t = (p < 0) ? -longint'(quo) : longint'(quo);
        e.pitch = scale_angle(cordic_atan2(t, longint'(c)));
        if (degrees_mode && yaw < 0) yaw += TURN_Q13;
        e.yaw = yaw;
        return e;
    endfunction

    // Send one quaternion; hold valid and payload until the transfer
    task automatic send_quat(quat_t q, bit bursty);
        if (bursty && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_quat_real <= q.qr;
        s_quat_i    <= q.qi;
        s_quat_j    <= q.qj;
        s_quat_k    <= q.qk;
        do @(posedge aclk); while (!s_ready);
        angle_queue.push_back(predict_euler(q));
        if (degrees_mode) n_deg++; else n_rad++;
    endtask

    // Let the pipeline drain completely before touching the unit register
    task automatic drain_and_write(bit deg);
        s_valid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= deg;
        @(posedge aclk);
        cfg_we <= 1'b0;
        degrees_mode = deg;
    endtask

    function automatic quat_t random_quat();
        quat_t q;
        int mode;
        mode = $urandom_range(0, 9);
        q = quat_t'({$urandom, $urandom});
        case (mode)
            0: begin
                // gimbal lock: equal magnitude pairs drive the arcsine to its limit
                q.qj = q.qr;
                q.qk = -q.qi;
            end
            1: begin
                q.qi = '0;
                q.qj = '0;
            end
            2: begin
                // small magnitudes exercise the operand normalization
                q.qr = $signed(5'($urandom));
                q.qi = $signed(5'($urandom));
                q.qj = $signed(5'($urandom));
                q.qk = $signed(5'($urandom));
            end
            3: q = '0;
            default: ;
        endcase
        return q;
    endfunction

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 16);
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Compare each output transfer against the oldest prediction
    always @(posedge aclk) begin
        euler_t want;
        if (aresetn && m_valid && m_ready) begin
            if (angle_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output transfer");
            end else begin
                want = angle_queue.pop_front();
                checked++;
                if (want.yaw !== m_yaw_angle || want.pitch !== m_pitch_angle ||
                    want.roll !== m_roll_angle || want.zero !== m_zero_norm) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp y=%0d p=%0d r=%0d z=%0b got y=%0d p=%0d r=%0d z=%0b",
                                 want.yaw, want.pitch, want.roll, want.zero,
                                 m_yaw_angle, m_pitch_angle, m_roll_angle, m_zero_norm);
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG) begin
                $display("watchdog expired");
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    localparam logic signed [QW-1:0] QMAX = 16'sh7FFF;
    localparam logic signed [QW-1:0] QMIN = -16'sh8000;
    localparam logic signed [QW-1:0] ONE  = 16'sh4000;
    localparam logic signed [QW-1:0] MONE = -16'sh4000;

    row_t directed [$];

    initial begin
        row_t rw;
        euler_t got;
        // zero quaternion: angles zeroed, flag raised
        directed.push_back('{'{0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b1}});
        // identity: all angles zero
        directed.push_back('{'{ONE, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{MONE, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{QMAX, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{QMIN, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0}});
        // pure i: roll is exactly +pi (negative x, zero y)
        directed.push_back('{'{0, ONE, 0, 0}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{0, 0, ONE, 0}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{0, 0, 0, ONE}, 1'b0, '{0, 0, 0, 1'b0}});
        // gimbal lock, both signs: arcsine saturated, yaw/roll operands zero
        directed.push_back('{'{ONE, 0, ONE, 0}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{ONE, 0, MONE, 0}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{QMIN, QMIN, QMIN, QMIN}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{QMAX, QMAX, QMAX, QMAX}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{QMAX, QMIN, QMAX, QMIN}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{1, 0, 0, 0}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{0, -1, 0, 1}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{16'sh2D41, 16'sh2D41, 0, 0}, 1'b0, '{0, 0, 0, 1'b0}});
        directed.push_back('{'{-16'sh5555, 16'sh1234, -16'sh0F0F, 16'sh7070}, 1'b0,
                             '{0, 0, 0, 1'b0}});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        degrees_mode = 1'b0;
        @(posedge aclk);

        // Directed table in radians, then again in degrees
        for (int pass = 0; pass < 2; pass++) begin
            foreach (directed[n]) begin
                rw = directed[n];
                send_quat(rw.q, 1'b0);
                // typed-in answers hold in both units; replace the prediction
                if (rw.fixed) begin
                    got = angle_queue.pop_back();
                    angle_queue.push_back(rw.ans);
                end
            end
            drain_and_write(pass == 0);
        end

        // Random traffic with unit changes at idle points; radians at the start, degrees at the end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) rx_hold = 1'b1;  // sender keeps offering through the hold-off
            if (n == 400) drain_and_write(1'b0);
            if (n == 800) drain_and_write(1'b1);
            if (n == 1100) begin
                drain_and_write(1'b0);
                rx_quiet = 1'b1;
            end
            if (n == 1200) drain_and_write(1'b1);
            send_quat(random_quat(), n < 1100);
        end
        s_valid <= 1'b0;

        while (angle_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);

        $display("covered %0d quaternions in radians and %0d in degrees, %0d results checked",
                 n_rad, n_deg, checked);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// ----- quaternion_to_euler_angles_core.f -----
hdl/qte_pkg.sv
hdl/qte_front.sv
hdl/qte_asin.sv
hdl/qte_cordic.sv
hdl/qte_scale.sv
hdl/quaternion_to_euler_angles_core.sv
verif/tb.sv
